### hw/rtl/crcfc_pkg.sv
`timescale 1ns / 1ps

package crcfc_pkg;

   typedef enum logic [2:0] {
      PH_WAIT   = 3'd0,
      PH_TYPE   = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_LEN_HI = 3'd3,
      PH_DATA   = 3'd4,
      PH_CRC_LO = 3'd5,
      PH_CRC_HI = 3'd6
   } phase_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_START = 2'd1;
   localparam logic [1:0] ST_CRC_ERR   = 2'd2;
   localparam logic [1:0] ST_LEN_ERR   = 2'd3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam int          HEADER_BYTES = 4;

   localparam int          CSR_ADDR_W       = 3;
   localparam logic        CSR_IDX_START    = 1'b0;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [7:0]  message_type;
      logic [15:0] frame_bytes;
      logic [1:0]  status;
      logic        last;
   } result_type;

   // byte-wide CRC-16/MODBUS update, LSB first
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### hw/rtl/crc16_frame_checker.sv
`timescale 1ns / 1ps
// A byte is held in the input register, and its result (if any) is registered in the output register.
// Throughput: one byte per cycle; the input register moves on whenever the
// output register is empty or being taken.
// Reset: synchronous, active high; clears frame state, CRC to 0xFFFF, start_value
// to zero and both pipeline registers to empty.
module crc16_frame_checker #(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_kind,
   output logic [7:0]                       rsp_payload_byte,
   output logic [7:0]                       rsp_message_type,
   output logic [15:0]                      rsp_frame_bytes,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_last,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [crcfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   logic [7:0]            start_value;
   logic                  in_full;
   logic [7:0]            in_byte;
   logic                  out_free;
   logic                  take;
   logic                  res_valid;
   crcfc_pkg::result_type res;
   crcfc_pkg::result_type rsp;

   assign take = in_full && out_free;

   crcfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .start_value (start_value)
   );

   crcfc_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .full        (in_full),
      .rx_byte     (in_byte)
   );

   crcfc_frame #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .rx_byte     (in_byte),
      .start_value (start_value),
      .res_valid   (res_valid),
      .res         (res)
   );

   crcfc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (take && res_valid),
      .res       (res),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_message_type = rsp.message_type;
   assign rsp_frame_bytes  = rsp.frame_bytes;
   assign rsp_status       = rsp.status;
   assign rsp_last         = rsp.last;

endmodule

### hw/rtl/crcfc_csr.sv
`timescale 1ns / 1ps

module crcfc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [crcfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output logic [7:0]                       start_value
);

   logic [7:0] start_value_ff;
   logic [7:0] start_value_in;
   logic       reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      start_value_in = start_value_ff;
      if (wr_en && reg_idx == crcfc_pkg::CSR_IDX_START && csr_paddr[1:0] == 2'b00) begin
         start_value_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff <= 8'h00;
      end else begin
         start_value_ff <= start_value_in;
      end
   end

   always_comb begin
      csr_prdata = 32'h0;
      if (reg_idx == crcfc_pkg::CSR_IDX_START && csr_paddr[1:0] == 2'b00) begin
         csr_prdata = {24'h0, start_value_ff};
      end
   end

   assign start_value = start_value_ff;

endmodule

### hw/rtl/crcfc_in_reg.sv
`timescale 1ns / 1ps

module crcfc_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       full,
   output logic [7:0] rx_byte
);

   logic       full_ff;
   logic       full_in;
   logic [7:0] byte_ff;
   logic       accept;

   // stall only while a held byte cannot move on this cycle
   assign req_stall = full_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      full_in = full_ff;
      if (accept) begin
         full_in = 1'b1;
      end else if (take) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign full    = full_ff;
   assign rx_byte = byte_ff;

endmodule

### hw/rtl/crcfc_frame.sv
`timescale 1ns / 1ps

module crcfc_frame #(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            start_value,
   output logic                  res_valid,
   output crcfc_pkg::result_type res
);

   localparam int          CNT_W   = $clog2(MAX_PAYLOAD + 1);
   localparam logic [16:0] LEN_MAX = 17'(MAX_PAYLOAD + 2);

   crcfc_pkg::phase_type phase_ff, phase_in;
   logic [15:0]      crc_ff, crc_in;
   logic [15:0]      len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;

   logic [15:0] crc_next;
   logic [15:0] len_full;
   logic [CNT_W-1:0] cnt_next;
   logic [16:0] fb_sum;
   logic [15:0] fb_sat;

   assign crc_next = crcfc_pkg::crc_update(crc_ff, rx_byte);
   assign len_full = {rx_byte, len_ff[7:0]};
   assign cnt_next = cnt_ff + CNT_W'(1);
   assign fb_sum   = {1'b0, len_ff} + 17'(crcfc_pkg::HEADER_BYTES);
   assign fb_sat   = fb_sum[16] ? 16'hFFFF : fb_sum[15:0];

   always_comb begin
      phase_in  = phase_ff;
      crc_in    = crc_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      type_in   = type_ff;
      crc_lo_in = crc_lo_ff;
      res_valid = 1'b0;
      res       = '0;
      res.message_type = type_ff;
      case (phase_ff)
         crcfc_pkg::PH_TYPE: begin
            type_in  = rx_byte;
            crc_in   = crc_next;
            phase_in = crcfc_pkg::PH_LEN_LO;
         end
         crcfc_pkg::PH_LEN_LO: begin
            len_in   = {8'h00, rx_byte};
            crc_in   = crc_next;
            phase_in = crcfc_pkg::PH_LEN_HI;
         end
         crcfc_pkg::PH_LEN_HI: begin
            if (len_full < 16'd2 || {1'b0, len_full} > LEN_MAX) begin
               res_valid  = 1'b1;
               res.kind   = crcfc_pkg::KIND_REPORT;
               res.status = crcfc_pkg::ST_LEN_ERR;
               res.last   = 1'b1;
               phase_in   = crcfc_pkg::PH_WAIT;
               crc_in     = crcfc_pkg::CRC_INIT;
               len_in     = 16'h0;
               cnt_in     = '0;
               crc_lo_in  = 8'h00;
            end else begin
               crc_in   = crc_next;
               len_in   = len_full;
               cnt_in   = '0;
               phase_in = (len_full == 16'd2) ? crcfc_pkg::PH_CRC_LO : crcfc_pkg::PH_DATA;
            end
         end
         crcfc_pkg::PH_DATA: begin
            crc_in = crc_next;
            cnt_in = cnt_next;
            if (16'(cnt_next) >= len_ff - 16'd2) begin
               phase_in = crcfc_pkg::PH_CRC_LO;
            end
            res_valid        = 1'b1;
            res.kind         = crcfc_pkg::KIND_PAYLOAD;
            res.payload_byte = rx_byte;
            res.status       = crcfc_pkg::ST_OK;
         end
         crcfc_pkg::PH_CRC_LO: begin
            crc_lo_in = rx_byte;
            phase_in  = crcfc_pkg::PH_CRC_HI;
         end
         crcfc_pkg::PH_CRC_HI: begin
            res_valid = 1'b1;
            res.kind  = crcfc_pkg::KIND_REPORT;
            res.last  = 1'b1;
            if ({rx_byte, crc_lo_ff} == crc_ff) begin
               res.status      = crcfc_pkg::ST_OK;
               res.frame_bytes = fb_sat;
            end else begin
               res.status = crcfc_pkg::ST_CRC_ERR;
            end
            phase_in  = crcfc_pkg::PH_WAIT;
            crc_in    = crcfc_pkg::CRC_INIT;
            len_in    = 16'h0;
            cnt_in    = '0;
            crc_lo_in = 8'h00;
         end
         default: begin
            // waiting for start byte; unused phase codes land here too
            len_in    = 16'h0;
            cnt_in    = '0;
            crc_lo_in = 8'h00;
            if (rx_byte != start_value) begin
               res_valid        = 1'b1;
               res.kind         = crcfc_pkg::KIND_REPORT;
               res.message_type = 8'h00;
               res.status       = crcfc_pkg::ST_BAD_START;
               res.last         = 1'b1;
               phase_in         = crcfc_pkg::PH_WAIT;
               crc_in           = crcfc_pkg::CRC_INIT;
            end else begin
               crc_in   = crcfc_pkg::crc_update(crcfc_pkg::CRC_INIT, rx_byte);
               phase_in = crcfc_pkg::PH_TYPE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= crcfc_pkg::PH_WAIT;
         crc_ff    <= crcfc_pkg::CRC_INIT;
         len_ff    <= 16'h0;
         cnt_ff    <= '0;
         type_ff   <= 8'h00;
         crc_lo_ff <= 8'h00;
      end else if (take) begin
         phase_ff  <= phase_in;
         crc_ff    <= crc_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         type_ff   <= type_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

endmodule

### hw/rtl/crcfc_out_reg.sv
`timescale 1ns / 1ps

module crcfc_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  crcfc_pkg::result_type res,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output crcfc_pkg::result_type rsp
);

   logic                  valid_ff;
   logic                  valid_in;
   crcfc_pkg::result_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule
